[hdl/winding_cycle_sequencer_top_defines.svh]
// Assertion macros for the winding cycle sequencer.
`ifndef WINDING_CYCLE_SEQUENCER_TOP_DEFINES_SVH
`define WINDING_CYCLE_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WCS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wcs assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wcs assertion failed");

`endif

[hdl/wcs_pkg.sv]
// Package: types, phase codes, register indexes and reset values of the sequencer.
package wcs_pkg;

  localparam int unsigned PptW    = 10;
  localparam int unsigned TurnsW  = 8;
  localparam int unsigned HalfW   = 16;
  localparam int unsigned RelayW  = 24;
  localparam int unsigned CountW  = PptW + TurnsW;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CfgIdxW  = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_PPT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TURNS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HALF  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RELAY = 2'd3;

  // Register reset values
  localparam logic [PptW-1:0]   PPT_RST   = 10'd100;
  localparam logic [TurnsW-1:0] TURNS_RST = 8'd2;
  localparam logic [HalfW-1:0]  HALF_RST  = 16'd50;
  localparam logic [RelayW-1:0] RELAY_RST = 24'd500000;

  // Sequence phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_WIND   = 3'd1;
  localparam logic [2:0] PH_Y_OUT  = 3'd2;
  localparam logic [2:0] PH_FOOT   = 3'd3;
  localparam logic [2:0] PH_RUN    = 3'd4;
  localparam logic [2:0] PH_X_OUT  = 3'd5;
  localparam logic [2:0] PH_Y_BACK = 3'd6;
  localparam logic [2:0] PH_X_BACK = 3'd7;

  typedef struct packed {
    logic start_req;
    logic x_home;
    logic x_far;
    logic y_home;
    logic y_far;
  } in_item_t;

  typedef struct packed {
    logic       step_line;
    logic       relay_x;
    logic       relay_y;
    logic       relay_foot;
    logic       relay_run;
    logic [2:0] phase;
  } out_item_t;

  // Settings seen by the sequencer core
  typedef struct packed {
    logic [CountW-1:0] target;
    logic [HalfW-1:0]  half;
    logic [RelayW-1:0] relay;
  } cfg_t;

endpackage

[hdl/wcs_if.sv]
// Valid/ready channel interfaces for sensor ticks and result levels.
interface wcs_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic x_home;
  logic x_far;
  logic y_home;
  logic y_far;

  modport source (output valid, start_req, x_home, x_far, y_home, y_far, input ready);
  modport sink (input valid, start_req, x_home, x_far, y_home, y_far, output ready);
endinterface

interface wcs_out_if;
  logic       valid;
  logic       ready;
  logic       step_line;
  logic       relay_x;
  logic       relay_y;
  logic       relay_foot;
  logic       relay_run;
  logic [2:0] phase;

  modport source (output valid, step_line, relay_x, relay_y, relay_foot, relay_run, phase,
                  input ready);
  modport sink (input valid, step_line, relay_x, relay_y, relay_foot, relay_run, phase,
                output ready);
endinterface

[hdl/wcs_cfg.sv]
// Configuration registers and the toggle target product.
module wcs_cfg import wcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  logic [PptW-1:0]   ppt_q;
  logic [TurnsW-1:0] turns_q;
  logic [HalfW-1:0]  half_q;
  logic [RelayW-1:0] relay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppt_q   <= PPT_RST;
      turns_q <= TURNS_RST;
      half_q  <= HALF_RST;
      relay_q <= RELAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PPT:   ppt_q   <= cfg_data_i[PptW-1:0];
        CFG_TURNS: turns_q <= cfg_data_i[TurnsW-1:0];
        CFG_HALF:  half_q  <= cfg_data_i[HalfW-1:0];
        CFG_RELAY: relay_q <= cfg_data_i[RelayW-1:0];
        default:   ppt_q   <= ppt_q;
      endcase
    end
  end

  // Small 10 x 8 product straight off the registers, valid right after a write.
  assign cfg_o = '{target: CountW'(ppt_q) * CountW'(turns_q), half: half_q, relay: relay_q};

endmodule

[hdl/wcs_core.sv]
// Sequencer state and the per-tick phase update.
`include "winding_cycle_sequencer_top_defines.svh"

module wcs_core import wcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  logic [2:0]        phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d;
  logic [HalfW-1:0]  since_q, since_d, since_inc;
  logic [RelayW-1:0] timer_q, timer_d, timer_inc;
  logic              armed_q, armed_d;
  logic              step_q, step_d;
  logic              x_q, x_d;
  logic              y_q, y_d;
  logic              foot_q, foot_d;
  logic              run_q, run_d;
  logic              relay_lvl;
  logic              relay_done;

  assign since_inc  = (since_q != '1) ? since_q + 1'b1 : since_q;
  assign timer_inc  = (timer_q != '1) ? timer_q + 1'b1 : timer_q;
  assign relay_done = (timer_inc > cfg_i.relay) || (timer_inc == '1);

  // Shared pulse logic for the foot and run relays
  always_comb begin
    if (!armed_q) begin
      relay_lvl = 1'b1;
    end else begin
      relay_lvl = !relay_done;
    end
  end

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    since_d = since_inc;
    timer_d = timer_q;
    armed_d = armed_q;
    step_d  = step_q;
    x_d     = x_q;
    y_d     = y_q;
    foot_d  = foot_q;
    run_d   = run_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (item_i.start_req) phase_d = PH_WIND;
      end
      PH_WIND: begin
        if (count_q < cfg_i.target) begin
          if ((since_inc > cfg_i.half) || (since_inc == '1)) begin
            step_d  = !step_q;
            since_d = '0;
            count_d = count_q + 1'b1;
          end
        end else begin
          phase_d = PH_Y_OUT;
        end
      end
      PH_Y_OUT: begin
        y_d = 1'b0;
        if (item_i.y_far) phase_d = PH_FOOT;
      end
      PH_FOOT, PH_RUN: begin
        if (phase_q == PH_FOOT) foot_d = relay_lvl;
        else run_d = relay_lvl;
        if (!armed_q) begin
          timer_d = '0;
          armed_d = 1'b1;
        end else begin
          timer_d = timer_inc;
          if (relay_done) begin
            armed_d = 1'b0;
            phase_d = phase_q + 3'd1;
          end
        end
      end
      PH_X_OUT: begin
        x_d = 1'b0;
        if (item_i.x_far) phase_d = PH_Y_BACK;
      end
      PH_Y_BACK: begin
        y_d = 1'b1;
        if (item_i.y_home) phase_d = PH_X_BACK;
      end
      PH_X_BACK: begin
        x_d = 1'b1;
        if (item_i.x_home) begin
          count_d = '0;
          phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      since_q <= '1;
      timer_q <= '0;
      armed_q <= 1'b0;
      step_q  <= 1'b0;
      x_q     <= 1'b0;
      y_q     <= 1'b0;
      foot_q  <= 1'b0;
      run_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      since_q <= since_d;
      timer_q <= timer_d;
      armed_q <= armed_d;
      step_q  <= step_d;
      x_q     <= x_d;
      y_q     <= y_d;
      foot_q  <= foot_d;
      run_q   <= run_d;
    end
  end

  assign res_o = '{step_line: step_d, relay_x: x_d, relay_y: y_d, relay_foot: foot_d,
                   relay_run: run_d, phase: phase_d};

  `WCS_ASSERT_IMPL(a_armed_in_pulse, armed_q, (phase_q == PH_FOOT) || (phase_q == PH_RUN))
  `WCS_ASSERT_IMPL(a_foot_in_phase, foot_q, phase_q == PH_FOOT)
  `WCS_ASSERT_IMPL(a_run_in_phase, run_q, phase_q == PH_RUN)
  `WCS_ASSERT_NEXT(a_hold_no_tick, !step_i, $stable(phase_q) && $stable(count_q))

endmodule

[hdl/winding_cycle_sequencer_top.sv]
// Top level of the winding cycle sequencer: channel registers around the core.
//
// Winding cycle sequencer. Each input transaction is one microsecond tick with a
// start request and the four cylinder limit sensors; each tick yields exactly one
// output transaction with the step line, the four relay levels and the phase after
// that tick. Phase 0 is idle and leaves only on start; phase 1 toggles the step line
// whenever more than toggle_half_period_us ticks have passed, until
// pulses_per_turn * turns toggles are done; phases 2..7 drive Y out, pulse foot,
// pulse run, drive X out, bring Y back, bring X back, then return to idle.
// Rate: one transaction per clock cycle sustained while out_o.ready is held high; the
// output is offered after its tick passes the input register, then the result register.
// The whole phase update is one pass of logic between those two registers.
// Configuration: write cfg_we_i/cfg_idx_i/cfg_data_i only while idle; index 0
// pulses_per_turn, 1 turns, 2 toggle_half_period_us, 3 relay_pulse_us. New settings,
// the turn product included, apply to every tick accepted from the write edge on.
// Reset: rst_ni is asynchronous, active low; no clearing pass is needed.
module winding_cycle_sequencer_top import wcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  wcs_in_if.sink              in_i,
  wcs_out_if.source           out_o
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t res;
  out_item_t out_q;
  logic      out_vld_q;
  logic      adv;

  wcs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Tick moves from the input register into the result register
  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= '{start_req: in_i.start_req, x_home: in_i.x_home, x_far: in_i.x_far,
                y_home: in_i.y_home, y_far: in_i.y_far};
    end
  end

  wcs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.step_line  = out_q.step_line;
  assign out_o.relay_x    = out_q.relay_x;
  assign out_o.relay_y    = out_q.relay_y;
  assign out_o.relay_foot = out_q.relay_foot;
  assign out_o.relay_run  = out_q.relay_run;
  assign out_o.phase      = out_q.phase;

endmodule
